@@ rtl/rda_pkg.sv @@
// Package for the region darkness alarm: widths, register indexes and reset values.
`timescale 1ns / 1ps

package rda_pkg;

    localparam int MAX_DIM_DEF = 4096;

    localparam int POS_W   = 12;
    localparam int LEN_W   = 13;
    localparam int THR_W   = 8;
    localparam int SEC_W   = 16;
    localparam int CFG_W   = 16;
    localparam int ADDR_W  = 3;
    localparam int SAMP_W  = 8;
    localparam int PIX_W   = 10;
    localparam int SUM_W   = 34;
    localparam int AREA_W  = 2 * LEN_W;
    localparam int THR3_W  = THR_W + 2;
    localparam int LIM_W   = AREA_W + THR3_W;
    localparam int TIME_W  = 32;
    localparam int S_DATA_W = 32;
    localparam int M_DATA_W = 8;

    typedef enum logic [ADDR_W-1:0] {
        REG_ROI_LEFT   = 3'd0,
        REG_ROI_TOP    = 3'd1,
        REG_ROI_WIDTH  = 3'd2,
        REG_ROI_HEIGHT = 3'd3,
        REG_DARK_THR   = 3'd4,
        REG_HOLD_SEC   = 3'd5,
        REG_SNOOZE_SEC = 3'd6
    } t_reg_idx;

    typedef enum logic {
        OP_PIXEL = 1'b0,
        OP_TICK  = 1'b1
    } t_op;

    localparam logic [POS_W-1:0] RST_ROI_LEFT   = '0;
    localparam logic [POS_W-1:0] RST_ROI_TOP    = '0;
    localparam logic [LEN_W-1:0] RST_ROI_WIDTH  = LEN_W'(64);
    localparam logic [LEN_W-1:0] RST_ROI_HEIGHT = LEN_W'(64);
    localparam logic [THR_W-1:0] RST_DARK_THR   = THR_W'(128);
    localparam logic [SEC_W-1:0] RST_HOLD_SEC   = SEC_W'(10);
    localparam logic [SEC_W-1:0] RST_SNOOZE_SEC = SEC_W'(60);

endpackage

@@ rtl/roi_darkness_alarm_core.sv @@
// Top level of the region darkness alarm: region sum, frame test and dark timer.
`timescale 1ns / 1ps
// A word accepted at the input passes the input register and the stage-1 register before the result register.
// Throughput: one word per cycle unless stalled; the output register lets the input keep flowing
// while a result waits, and only pixel words that end a frame ever wait on m_axis_tready.
// The region limit 3*threshold*area comes from two registered multiplies of the config.
// Reset (synchronous, active low) clears counters, sum, timer, clock and valid flags, and loads config reset values.
module roi_darkness_alarm_core
    import rda_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // config write port
    input  logic                i_cfg_we,
    input  logic [ADDR_W-1:0]   i_cfg_addr,
    input  logic [CFG_W-1:0]    i_cfg_data,
    // input stream
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [S_DATA_W-1:0] s_axis_tdata,  // red[7:0] green[15:8] blue[23:16] end_of_line[24]
    input  logic                s_axis_tuser,  // operation[0]
    input  logic                s_axis_tlast,  // end_of_frame
    // result stream
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [M_DATA_W-1:0] m_axis_tdata   // frame_dark[0] alarm[1] timer_running[2]
);

    localparam int CNT_W = $clog2(MAX_DIM + 1);
    localparam int CMP_W = ((CNT_W > LEN_W) ? CNT_W : LEN_W) + 1;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_DIM);
    localparam logic [SUM_W-1:0] SUM_MAX = '1;
    localparam logic [TIME_W-1:0] ELAPSED_MAX = '1;

    // ---------------- configuration ----------------
    logic [POS_W-1:0] r_roi_left, r_roi_top;
    logic [LEN_W-1:0] r_roi_width, r_roi_height;
    logic [THR_W-1:0] r_dark_thr;
    logic [SEC_W-1:0] r_hold_sec, r_snooze_sec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_roi_left   <= RST_ROI_LEFT;
            r_roi_top    <= RST_ROI_TOP;
            r_roi_width  <= RST_ROI_WIDTH;
            r_roi_height <= RST_ROI_HEIGHT;
            r_dark_thr   <= RST_DARK_THR;
            r_hold_sec   <= RST_HOLD_SEC;
            r_snooze_sec <= RST_SNOOZE_SEC;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_addr))
                REG_ROI_LEFT:   r_roi_left   <= i_cfg_data[POS_W-1:0];
                REG_ROI_TOP:    r_roi_top    <= i_cfg_data[POS_W-1:0];
                REG_ROI_WIDTH:  r_roi_width  <= i_cfg_data[LEN_W-1:0];
                REG_ROI_HEIGHT: r_roi_height <= i_cfg_data[LEN_W-1:0];
                REG_DARK_THR:   r_dark_thr   <= i_cfg_data[THR_W-1:0];
                REG_HOLD_SEC:   r_hold_sec   <= i_cfg_data[SEC_W-1:0];
                REG_SNOOZE_SEC: r_snooze_sec <= i_cfg_data[SEC_W-1:0];
                default: ;
            endcase
        end
    end

    // limit = area * 3*threshold, two multiplies each followed by a register
    logic [AREA_W-1:0] r_area;
    logic [LIM_W-1:0]  r_limit;
    logic [THR3_W-1:0] thr3;

    assign thr3 = THR3_W'({r_dark_thr, 1'b0}) + THR3_W'(r_dark_thr);

    always_ff @(posedge i_clk) begin
        r_area  <= AREA_W'(r_roi_width) * AREA_W'(r_roi_height);
        r_limit <= LIM_W'(r_area) * LIM_W'(thr3);
    end

    // ---------------- handshake ----------------
    logic r_v0, r_v1, r_ov;
    logic adv0, adv1, s1_load_ok, out_free, s1_has_result;

    logic              r_in_op, r_in_eol, r_in_eof;
    logic [SAMP_W-1:0] r_in_red, r_in_green, r_in_blue;
    logic              r_s1_op, r_s1_eof;
    logic [SUM_W-1:0]  r_s1_sum;

    assign out_free      = !r_ov || m_axis_tready;
    assign s1_has_result = (r_s1_op == OP_PIXEL) && r_s1_eof;
    assign adv1          = r_v1 && (!s1_has_result || out_free);
    assign s1_load_ok    = !r_v1 || adv1;
    assign adv0          = r_v0 && s1_load_ok;
    assign s_axis_tready = i_rst_n && (!r_v0 || s1_load_ok);

    // ---------------- stage 0: input register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_v0 <= 1'b1;
        end else if (adv0) begin
            r_v0 <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_op    <= s_axis_tuser;
            r_in_red   <= s_axis_tdata[7:0];
            r_in_green <= s_axis_tdata[15:8];
            r_in_blue  <= s_axis_tdata[23:16];
            r_in_eol   <= s_axis_tdata[24];
            r_in_eof   <= s_axis_tlast;
        end
    end

    // ---------------- stage 1: raster position and region sum ----------------
    logic [CNT_W-1:0] r_col, r_row;
    logic [SUM_W-1:0] r_sum;
    logic [PIX_W-1:0] px;
    logic [SUM_W:0]   sum_wide;
    logic [SUM_W-1:0] sum_next;
    logic             col_in, row_in;

    always_comb begin
        logic [CMP_W-1:0] pc, pr, lc, lr;
        pc = CMP_W'(r_col);
        pr = CMP_W'(r_row);
        lc = CMP_W'(r_roi_left);
        lr = CMP_W'(r_roi_top);
        col_in = (r_col < CNT_MAX) && (pc >= lc) && ((pc - lc) < CMP_W'(r_roi_width));
        row_in = (r_row < CNT_MAX) && (pr >= lr) && ((pr - lr) < CMP_W'(r_roi_height));
    end

    assign px       = PIX_W'(r_in_red) + PIX_W'(r_in_green) + PIX_W'(r_in_blue);
    assign sum_wide = (col_in && row_in) ? ({1'b0, r_sum} + (SUM_W+1)'(px))
                                         : {1'b0, r_sum};
    assign sum_next = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
            r_sum <= '0;
        end else if (adv0 && (r_in_op == OP_PIXEL)) begin
            if (r_in_eof) begin
                r_col <= '0;
                r_row <= '0;
                r_sum <= '0;
            end else begin
                r_sum <= sum_next;
                if (r_in_eol) begin
                    r_col <= '0;
                    if (r_row < CNT_MAX) r_row <= r_row + 1'b1;
                end else if (r_col < CNT_MAX) begin
                    r_col <= r_col + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (adv0) begin
            r_v1 <= 1'b1;
        end else if (adv1) begin
            r_v1 <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv0) begin
            r_s1_op  <= r_in_op;
            r_s1_eof <= r_in_eof;
            r_s1_sum <= sum_next;
        end
    end

    // ---------------- stage 2: frame test and dark timer ----------------
    logic              r_active;
    logic [TIME_W-1:0] r_elapsed, r_now, r_last_alarm;
    logic [SEC_W-1:0]  r_cooldown;

    logic              dark, n_alarm, n_active;
    logic [TIME_W-1:0] n_elapsed, since_alarm;

    assign dark        = !(LIM_W'(r_s1_sum) > r_limit);
    assign since_alarm = r_now - r_last_alarm;

    always_comb begin
        n_active  = r_active;
        n_elapsed = r_elapsed;
        n_alarm   = 1'b0;
        if (!dark) begin
            if (r_active && (r_elapsed > TIME_W'(r_cooldown))) begin
                n_active  = 1'b0;
                n_elapsed = '0;
            end
        end else begin
            if (!r_active) begin
                n_active  = 1'b1;
                n_elapsed = '0;
            end
            if ((n_elapsed > TIME_W'(r_hold_sec)) && (since_alarm > TIME_W'(r_cooldown))) begin
                n_alarm   = 1'b1;
                n_active  = 1'b0;
                n_elapsed = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active     <= 1'b0;
            r_elapsed    <= '0;
            r_now        <= '0;
            r_last_alarm <= '0;
            r_cooldown   <= '0;
        end else if (adv1) begin
            if (r_s1_op == OP_TICK) begin
                r_now <= r_now + 1'b1;
                if (r_active && (r_elapsed != ELAPSED_MAX)) r_elapsed <= r_elapsed + 1'b1;
            end else if (r_s1_eof) begin
                r_active  <= n_active;
                r_elapsed <= n_elapsed;
                if (n_alarm) begin
                    r_last_alarm <= r_now;
                    r_cooldown   <= r_snooze_sec;
                end
            end
        end
    end

    // ---------------- result register ----------------
    logic r_out_dark, r_out_alarm, r_out_timer;
    logic load_out;

    assign load_out = adv1 && s1_has_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (load_out) begin
            r_ov <= 1'b1;
        end else if (m_axis_tready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_dark  <= dark;
            r_out_alarm <= n_alarm;
            r_out_timer <= n_active;
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = {5'b0, r_out_timer, r_out_alarm, r_out_dark};

    // ---------------- checks ----------------
    a_alarm_on_dark_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_out_alarm) |-> (r_out_dark && !r_out_timer))
        else $error("alarm reported on a bright frame or with timer left running");

    a_idle_timer_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_active |-> (r_elapsed == '0))
        else $error("dark timer holds time while stopped");

    a_counters_capped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_col <= CNT_MAX) && (r_row <= CNT_MAX))
        else $error("raster counter passed its cap");

    a_alarm_stamps_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load_out && n_alarm) |=> ((r_last_alarm == r_now) && (r_cooldown == $past(r_snooze_sec))))
        else $error("alarm did not stamp time and cooldown");

endmodule
